// ----- rtl/dual_wheel_pi_speed_drive_top_macros.svh -----
// assertion macros for the two-wheel pi speed drive
// used by the top level; expects clk and rst_n in the including scope
`ifndef DUAL_WHEEL_PI_SPEED_DRIVE_TOP_MACROS_SVH
`define DUAL_WHEEL_PI_SPEED_DRIVE_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define DWPSD_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("dwpsd check failed");
`define DWPSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dwpsd check failed");
`else
`define DWPSD_ASSERT(lbl, expr)
`define DWPSD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/dwpsd_pkg.sv -----
// shared constants, register codes and control structs for the pi speed drive
// no dependencies
package dwpsd_pkg;

  localparam int UPDATE_DIVIDE = 2;
  localparam int DIV_W = (UPDATE_DIVIDE > 1) ? $clog2(UPDATE_DIVIDE) : 1;
  localparam logic [DIV_W-1:0] DIV_LAST = DIV_W'(UPDATE_DIVIDE - 1);

  localparam int SPD_W  = 16;
  localparam int ERR_W  = 11;
  localparam int INT_W  = 23;
  localparam int OUT_W  = 24;
  localparam int DRV_W  = 13;
  localparam int PWM_W  = 12;
  localparam int GAIN_W = 16;
  localparam int Q_SHIFT = 12;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int ERR_MAX   = 800;
  localparam int INTEG_MAX = 600 * 4096;
  localparam int OUT_MAX   = 999 * 4096;

  localparam logic [1:0] MODE_OPEN   = 2'd0;
  localparam logic [1:0] MODE_CLOSED = 2'd1;
  localparam logic       PID_POS     = 1'b0;
  localparam logic       PID_INC     = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_CTRL_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PID_MODE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MOTOR_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_DIR    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_DIR   = 3'd6;

  localparam logic [PWM_W-1:0] LIMIT_RESET = 12'd999;

  typedef struct packed {
    logic [1:0]        ctrl_mode;
    logic              pid_mode;
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain;
    logic [PWM_W-1:0]  motor_limit;
    logic              left_dir;
    logic              right_dir;
  } cfg_t;

  typedef struct packed {
    logic              run;
    logic              pid_mode;
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
  } pi_ctrl_t;

  typedef struct packed {
    logic [1:0]       ctrl_mode;
    logic             open_valid;
    logic             locked;
    logic             swap;
    logic [PWM_W-1:0] limit;
    logic             step;
  } drv_ctrl_t;

endpackage

// ----- rtl/dwpsd_cfg_if.sv -----
// configuration write channel: valid, ready, register index and data
// depends on dwpsd_pkg
interface dwpsd_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [dwpsd_pkg::CFG_IDX_W-1:0]     index;
  logic [dwpsd_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/dwpsd_in_if.sv -----
// input tick channel: targets, measured speeds, open-loop command and lock
// depends on dwpsd_pkg
interface dwpsd_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [dwpsd_pkg::SPD_W-1:0]  left_target;
  logic signed [dwpsd_pkg::SPD_W-1:0]  right_target;
  logic signed [dwpsd_pkg::SPD_W-1:0]  left_speed;
  logic signed [dwpsd_pkg::SPD_W-1:0]  right_speed;
  logic                                open_loop_valid;
  logic signed [dwpsd_pkg::DRV_W-1:0]  open_left_pwm;
  logic signed [dwpsd_pkg::DRV_W-1:0]  open_right_pwm;
  logic                                locked;

  modport source (output valid, output left_target, output right_target, output left_speed,
                  output right_speed, output open_loop_valid, output open_left_pwm,
                  output open_right_pwm, output locked, input ready);
  modport sink   (input valid, input left_target, input right_target, input left_speed,
                  input right_speed, input open_loop_valid, input open_left_pwm,
                  input open_right_pwm, input locked, output ready);
endinterface

// ----- rtl/dwpsd_out_if.sv -----
// result channel: bridge channel widths, signed drives and update flag
// depends on dwpsd_pkg
interface dwpsd_out_if;
  logic                                valid;
  logic                                ready;
  logic [dwpsd_pkg::PWM_W-1:0]         right_chan_a;
  logic [dwpsd_pkg::PWM_W-1:0]         right_chan_b;
  logic [dwpsd_pkg::PWM_W-1:0]         left_chan_a;
  logic [dwpsd_pkg::PWM_W-1:0]         left_chan_b;
  logic signed [dwpsd_pkg::DRV_W-1:0]  left_drive;
  logic signed [dwpsd_pkg::DRV_W-1:0]  right_drive;
  logic                                control_ran;

  modport source (output valid, output right_chan_a, output right_chan_b, output left_chan_a,
                  output left_chan_b, output left_drive, output right_drive,
                  output control_ran, input ready);
  modport sink   (input valid, input right_chan_a, input right_chan_b, input left_chan_a,
                  input left_chan_b, input left_drive, input right_drive,
                  input control_ran, output ready);
endinterface

// ----- rtl/dwpsd_pi_wheel.sv -----
// one wheel of the pi controller: error clamp, positional or incremental update
// holds error, integral and output state; depends on dwpsd_pkg
module dwpsd_pi_wheel (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dwpsd_pkg::pi_ctrl_t                 ctrl,
  input  logic signed [dwpsd_pkg::SPD_W-1:0]  target,
  input  logic signed [dwpsd_pkg::SPD_W-1:0]  speed,
  output logic signed [dwpsd_pkg::OUT_W-1:0]  out_q12
);

  localparam int DIFF_W = dwpsd_pkg::SPD_W + 1;
  localparam int DERR_W = dwpsd_pkg::ERR_W + 1;
  localparam int PP_W   = dwpsd_pkg::GAIN_W + 1 + DERR_W;
  localparam int IP_W   = dwpsd_pkg::GAIN_W + 1 + dwpsd_pkg::ERR_W;
  localparam int IS_W   = IP_W + 1;
  localparam int PS_W   = PP_W + 1;
  localparam int NS_W   = PP_W + 2;

  localparam logic signed [DIFF_W-1:0] E_HI = DIFF_W'(dwpsd_pkg::ERR_MAX);
  localparam logic signed [DIFF_W-1:0] E_LO = -DIFF_W'(dwpsd_pkg::ERR_MAX);
  localparam logic signed [IS_W-1:0]   I_HI = IS_W'(dwpsd_pkg::INTEG_MAX);
  localparam logic signed [IS_W-1:0]   I_LO = -IS_W'(dwpsd_pkg::INTEG_MAX);
  localparam logic signed [NS_W-1:0]   O_HI = NS_W'(dwpsd_pkg::OUT_MAX);
  localparam logic signed [NS_W-1:0]   O_LO = -NS_W'(dwpsd_pkg::OUT_MAX);

  logic signed [dwpsd_pkg::ERR_W-1:0] err_r;
  logic signed [dwpsd_pkg::INT_W-1:0] integ_r;
  logic signed [dwpsd_pkg::OUT_W-1:0] out_r;

  logic signed [DIFF_W-1:0]           diff;
  logic signed [dwpsd_pkg::ERR_W-1:0] err_nxt;
  logic signed [DERR_W-1:0]           derr;
  logic signed [DERR_W-1:0]           p_sel;
  logic signed [PP_W-1:0]             p_prod;
  logic signed [IP_W-1:0]             i_prod;
  logic signed [IS_W-1:0]             integ_sum;
  logic signed [dwpsd_pkg::INT_W-1:0] integ_nxt;
  logic signed [PS_W-1:0]             pos_sum;
  logic signed [NS_W-1:0]             inc_sum;
  logic signed [NS_W-1:0]             new_sum;
  logic signed [dwpsd_pkg::OUT_W-1:0] out_nxt;

  always_comb begin
    diff = DIFF_W'(target) - DIFF_W'(speed);
    if (diff > E_HI) begin
      err_nxt = E_HI[dwpsd_pkg::ERR_W-1:0];
    end else if (diff < E_LO) begin
      err_nxt = E_LO[dwpsd_pkg::ERR_W-1:0];
    end else begin
      err_nxt = diff[dwpsd_pkg::ERR_W-1:0];
    end

    derr  = DERR_W'(err_nxt) - DERR_W'(err_r);
    // incremental form scales the error change, positional the error itself
    p_sel = (ctrl.pid_mode == dwpsd_pkg::PID_INC) ? derr : DERR_W'(err_nxt);
    p_prod = $signed({1'b0, ctrl.kp}) * p_sel;
    i_prod = $signed({1'b0, ctrl.ki}) * err_nxt;

    integ_sum = IS_W'(integ_r) + IS_W'(i_prod);
    if (integ_sum > I_HI) begin
      integ_nxt = I_HI[dwpsd_pkg::INT_W-1:0];
    end else if (integ_sum < I_LO) begin
      integ_nxt = I_LO[dwpsd_pkg::INT_W-1:0];
    end else begin
      integ_nxt = integ_sum[dwpsd_pkg::INT_W-1:0];
    end

    pos_sum = PS_W'(integ_nxt) + PS_W'(p_prod);
    inc_sum = NS_W'(out_r) + NS_W'(p_prod) + NS_W'(i_prod);
    new_sum = (ctrl.pid_mode == dwpsd_pkg::PID_INC) ? inc_sum : NS_W'(pos_sum);

    if (new_sum > O_HI) begin
      out_nxt = O_HI[dwpsd_pkg::OUT_W-1:0];
    end else if (new_sum < O_LO) begin
      out_nxt = O_LO[dwpsd_pkg::OUT_W-1:0];
    end else begin
      out_nxt = new_sum[dwpsd_pkg::OUT_W-1:0];
    end

    out_q12 = ctrl.run ? out_nxt : out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r   <= '0;
      integ_r <= '0;
      out_r   <= '0;
    end else if (ctrl.run) begin
      err_r <= err_nxt;
      out_r <= out_nxt;
      if (ctrl.pid_mode == dwpsd_pkg::PID_POS) begin
        integ_r <= integ_nxt;
      end
    end
  end

endmodule

// ----- rtl/dwpsd_bridge.sv -----
// drive selection, lock, motor limit and h-bridge split for one motor
// holds the last drive for open loop without a command; depends on dwpsd_pkg
module dwpsd_bridge (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dwpsd_pkg::drv_ctrl_t                ctrl,
  input  logic signed [dwpsd_pkg::DRV_W-1:0]  open_pwm,
  input  logic signed [dwpsd_pkg::OUT_W-1:0]  out_q12,
  output logic signed [dwpsd_pkg::DRV_W-1:0]  drive,
  output logic [dwpsd_pkg::PWM_W-1:0]         fwd,
  output logic [dwpsd_pkg::PWM_W-1:0]         rev
);

  localparam int CNT_W = dwpsd_pkg::OUT_W - dwpsd_pkg::Q_SHIFT;
  localparam int DW    = dwpsd_pkg::DRV_W;

  logic signed [DW-1:0]               held_r;
  logic signed [CNT_W-1:0]            cnt_floor;
  logic                               round_up;
  logic signed [DW-1:0]               closed_cnt;
  logic signed [DW-1:0]               sel;
  logic signed [DW-1:0]               lim;
  logic signed [DW-1:0]               drive_nxt;
  logic [dwpsd_pkg::PWM_W-1:0]        mag;
  logic [dwpsd_pkg::PWM_W-1:0]        pos_part;
  logic [dwpsd_pkg::PWM_W-1:0]        neg_part;

  always_comb begin
    // q.12 to counts, truncated toward zero
    cnt_floor  = out_q12[dwpsd_pkg::OUT_W-1:dwpsd_pkg::Q_SHIFT];
    round_up   = out_q12[dwpsd_pkg::OUT_W-1] && (|out_q12[dwpsd_pkg::Q_SHIFT-1:0]);
    closed_cnt = DW'(cnt_floor) + DW'({1'b0, round_up});

    unique case (ctrl.ctrl_mode)
      dwpsd_pkg::MODE_OPEN:   sel = ctrl.open_valid ? open_pwm : held_r;
      dwpsd_pkg::MODE_CLOSED: sel = closed_cnt;
      default:                sel = '0;
    endcase
    if (ctrl.locked) begin
      sel = '0;
    end

    lim = $signed({1'b0, ctrl.limit});
    if (sel > lim) begin
      drive_nxt = lim;
    end else if (sel < -lim) begin
      drive_nxt = -lim;
    end else begin
      drive_nxt = sel;
    end
    drive = drive_nxt;

    mag      = drive_nxt[DW-1] ? dwpsd_pkg::PWM_W'(-drive_nxt)
                               : drive_nxt[dwpsd_pkg::PWM_W-1:0];
    pos_part = drive_nxt[DW-1] ? '0 : mag;
    neg_part = drive_nxt[DW-1] ? mag : '0;
    fwd      = ctrl.swap ? neg_part : pos_part;
    rev      = ctrl.swap ? pos_part : neg_part;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (ctrl.step) begin
      held_r <= drive_nxt;
    end
  end

endmodule

// ----- rtl/dual_wheel_pi_speed_drive_top.sv -----
// two-wheel pi speed drive: an input beat goes through the input register,
// then the result register; throughput one beat per cycle while the result
// side takes beats; each tick's pi update and drive mapping
// sit between those two registers. synchronous active-low reset restores the
// configuration defaults and clears divider, controller and held drive state
`include "dual_wheel_pi_speed_drive_top_macros.svh"
module dual_wheel_pi_speed_drive_top (
  input  logic         clk,
  input  logic         rst_n,
  dwpsd_cfg_if.sink    cfg_chan,
  dwpsd_in_if.sink     in_chan,
  dwpsd_out_if.source  out_chan
);

  dwpsd_pkg::cfg_t cfg_r;

  logic                                in_valid_r;
  logic signed [dwpsd_pkg::SPD_W-1:0]  in_left_target_r;
  logic signed [dwpsd_pkg::SPD_W-1:0]  in_right_target_r;
  logic signed [dwpsd_pkg::SPD_W-1:0]  in_left_speed_r;
  logic signed [dwpsd_pkg::SPD_W-1:0]  in_right_speed_r;
  logic                                in_open_valid_r;
  logic signed [dwpsd_pkg::DRV_W-1:0]  in_open_left_r;
  logic signed [dwpsd_pkg::DRV_W-1:0]  in_open_right_r;
  logic                                in_locked_r;

  logic [dwpsd_pkg::DIV_W-1:0]         div_cnt_r;

  logic                                out_valid_r;
  logic [dwpsd_pkg::PWM_W-1:0]         out_right_chan_a_r;
  logic [dwpsd_pkg::PWM_W-1:0]         out_right_chan_b_r;
  logic [dwpsd_pkg::PWM_W-1:0]         out_left_chan_a_r;
  logic [dwpsd_pkg::PWM_W-1:0]         out_left_chan_b_r;
  logic signed [dwpsd_pkg::DRV_W-1:0]  out_left_drive_r;
  logic signed [dwpsd_pkg::DRV_W-1:0]  out_right_drive_r;
  logic                                out_control_ran_r;

  logic                                adv;
  logic                                closed;
  logic                                run;
  dwpsd_pkg::pi_ctrl_t                 pi_ctrl;
  dwpsd_pkg::drv_ctrl_t                left_ctrl;
  dwpsd_pkg::drv_ctrl_t                right_ctrl;
  logic signed [dwpsd_pkg::OUT_W-1:0]  left_q12;
  logic signed [dwpsd_pkg::OUT_W-1:0]  right_q12;
  logic signed [dwpsd_pkg::DRV_W-1:0]  left_drive;
  logic signed [dwpsd_pkg::DRV_W-1:0]  right_drive;
  logic [dwpsd_pkg::PWM_W-1:0]         left_fwd;
  logic [dwpsd_pkg::PWM_W-1:0]         left_rev;
  logic [dwpsd_pkg::PWM_W-1:0]         right_fwd;
  logic [dwpsd_pkg::PWM_W-1:0]         right_rev;

  // configuration registers
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ctrl_mode   <= dwpsd_pkg::MODE_CLOSED;
      cfg_r.pid_mode    <= dwpsd_pkg::PID_POS;
      cfg_r.prop_gain   <= '0;
      cfg_r.integ_gain  <= '0;
      cfg_r.motor_limit <= dwpsd_pkg::LIMIT_RESET;
      cfg_r.left_dir    <= 1'b0;
      cfg_r.right_dir   <= 1'b0;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        dwpsd_pkg::REG_CTRL_MODE:   cfg_r.ctrl_mode   <= cfg_chan.data[1:0];
        dwpsd_pkg::REG_PID_MODE:    cfg_r.pid_mode    <= cfg_chan.data[0];
        dwpsd_pkg::REG_PROP_GAIN:   cfg_r.prop_gain   <= cfg_chan.data;
        dwpsd_pkg::REG_INTEG_GAIN:  cfg_r.integ_gain  <= cfg_chan.data;
        dwpsd_pkg::REG_MOTOR_LIMIT:
          cfg_r.motor_limit <= cfg_chan.data[dwpsd_pkg::PWM_W-1:0];
        dwpsd_pkg::REG_LEFT_DIR:    cfg_r.left_dir    <= cfg_chan.data[0];
        dwpsd_pkg::REG_RIGHT_DIR:   cfg_r.right_dir   <= cfg_chan.data[0];
        default: ;
      endcase
    end
  end

  // input register: takes a new beat when empty or whenever the held one moves on
  assign adv           = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_left_target_r  <= in_chan.left_target;
      in_right_target_r <= in_chan.right_target;
      in_left_speed_r   <= in_chan.left_speed;
      in_right_speed_r  <= in_chan.right_speed;
      in_open_valid_r   <= in_chan.open_loop_valid;
      in_open_left_r    <= in_chan.open_left_pwm;
      in_open_right_r   <= in_chan.open_right_pwm;
      in_locked_r       <= in_chan.locked;
    end
  end

  // update divider, counts only in closed loop
  assign closed = (cfg_r.ctrl_mode == dwpsd_pkg::MODE_CLOSED);
  assign run    = adv && closed && (div_cnt_r == dwpsd_pkg::DIV_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (adv && closed) begin
      div_cnt_r <= run ? '0 : dwpsd_pkg::DIV_W'(div_cnt_r + 1'b1);
    end
  end

  always_comb begin
    pi_ctrl.run      = run;
    pi_ctrl.pid_mode = cfg_r.pid_mode;
    pi_ctrl.kp       = cfg_r.prop_gain;
    pi_ctrl.ki       = cfg_r.integ_gain;

    left_ctrl.ctrl_mode  = cfg_r.ctrl_mode;
    left_ctrl.open_valid = in_open_valid_r;
    left_ctrl.locked     = in_locked_r;
    left_ctrl.swap       = cfg_r.left_dir;
    left_ctrl.limit      = cfg_r.motor_limit;
    left_ctrl.step       = adv;

    right_ctrl       = left_ctrl;
    right_ctrl.swap  = cfg_r.right_dir;
  end

  dwpsd_pi_wheel u_pi_left (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (pi_ctrl),
    .target  (in_left_target_r),
    .speed   (in_left_speed_r),
    .out_q12 (left_q12)
  );

  dwpsd_pi_wheel u_pi_right (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (pi_ctrl),
    .target  (in_right_target_r),
    .speed   (in_right_speed_r),
    .out_q12 (right_q12)
  );

  dwpsd_bridge u_bridge_left (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (left_ctrl),
    .open_pwm (in_open_left_r),
    .out_q12  (left_q12),
    .drive    (left_drive),
    .fwd      (left_fwd),
    .rev      (left_rev)
  );

  dwpsd_bridge u_bridge_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (right_ctrl),
    .open_pwm (in_open_right_r),
    .out_q12  (right_q12),
    .drive    (right_drive),
    .fwd      (right_fwd),
    .rev      (right_rev)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // left forward is channel a, right forward is channel b
  always_ff @(posedge clk) begin
    if (adv) begin
      out_left_chan_a_r  <= left_fwd;
      out_left_chan_b_r  <= left_rev;
      out_right_chan_b_r <= right_fwd;
      out_right_chan_a_r <= right_rev;
      out_left_drive_r   <= left_drive;
      out_right_drive_r  <= right_drive;
      out_control_ran_r  <= run;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.right_chan_a = out_right_chan_a_r;
  assign out_chan.right_chan_b = out_right_chan_b_r;
  assign out_chan.left_chan_a  = out_left_chan_a_r;
  assign out_chan.left_chan_b  = out_left_chan_b_r;
  assign out_chan.left_drive   = out_left_drive_r;
  assign out_chan.right_drive  = out_right_drive_r;
  assign out_chan.control_ran  = out_control_ran_r;

  `DWPSD_ASSERT_NEXT(a_in_hold, in_valid_r && !adv, in_valid_r)
  `DWPSD_ASSERT_NEXT(a_div_restart, run, div_cnt_r == '0)
  `DWPSD_ASSERT_NEXT(a_lock_zero, adv && in_locked_r, out_left_drive_r == '0 && out_right_drive_r == '0)
  `DWPSD_ASSERT(a_left_one_side, !out_valid_r || out_left_chan_a_r == '0 || out_left_chan_b_r == '0)
  `DWPSD_ASSERT(a_right_one_side, !out_valid_r || out_right_chan_a_r == '0 || out_right_chan_b_r == '0)

endmodule
